// ===== hdl/rtce_pkg.sv =====
// Shared types, constants and calendar tables for the RTC calendar-to-epoch unit.
package rtce_pkg;

    // Field and register widths
    localparam int EPOCH_W     = 34;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 9;

    // Cycles from an accepted transfer to its result strobe
    localparam int LATENCY = 9;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_YEAR_OFFSET = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_YEAR    = 1'b1;

    // Register reset values
    localparam logic [7:0] YEAR_OFFSET_RESET = 8'd68;
    localparam logic [8:0] MIN_YEAR_RESET    = 9'd70;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_ZERO    = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    // Calendar constants
    localparam logic [11:0] CAL_YEAR_ORIGIN = 12'd1900;
    localparam logic [3:0]  MONTH_FEB      = 4'd2;
    localparam logic [3:0]  MONTH_DEC      = 4'd12;
    localparam logic [16:0] SECS_PER_HOUR  = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN   = 17'd60;
    localparam logic [16:0] DAY_SECONDS    = 17'd86400;
    localparam logic [20:0] DAY_BIAS       = 21'd719499;

    // n/100 == (n * 5243) >> 19 for n below 43690
    localparam logic [12:0] DIV100_RECIP   = 13'd5243;
    // floor(2^37 / 675); seconds / 86400 == (seconds >> 7) / 675
    localparam logic [27:0] DIV675_RECIP   = 28'd203613264;
    localparam logic [26:0] DIV675_DIVISOR = 27'd675;

    // Sideband that travels with the timestamp through the weekday stages
    typedef struct packed {
        logic        bad;
        logic [11:0] full_year;
        logic [3:0]  month;
    } rtce_meta_t;

    // (367 * m) / 12 for the March-based month number m (1..13)
    function automatic logic [8:0] month_term(input logic [3:0] m);
        logic [8:0] v;
        case (m)
            4'd1:    v = 9'd30;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd91;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd152;
            4'd6:    v = 9'd183;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd244;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd305;
            4'd11:   v = 9'd336;
            4'd12:   v = 9'd367;
            4'd13:   v = 9'd397;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // Days in a month of a common year; out-of-range months give zero
    function automatic logic [4:0] month_length(input logic [3:0] mon);
        logic [4:0] v;
        case (mon)
            4'd1:    v = 5'd31;
            4'd2:    v = 5'd28;
            4'd3:    v = 5'd31;
            4'd4:    v = 5'd30;
            4'd5:    v = 5'd31;
            4'd6:    v = 5'd30;
            4'd7:    v = 5'd31;
            4'd8:    v = 5'd31;
            4'd9:    v = 5'd30;
            4'd10:   v = 5'd31;
            4'd11:   v = 5'd30;
            4'd12:   v = 5'd31;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

    // Quotient by 100 of a 12-bit year
    function automatic logic [5:0] div100(input logic [11:0] v);
        logic [24:0] p;
        p = {13'b0, v} * {12'b0, DIV100_RECIP};
        return p[24:19];
    endfunction

endpackage

// ===== hdl/rtce_weekday.sv =====
// Pipelined divide by 86400 and mod-7 weekday stage for the calendar-to-epoch unit.
module rtce_weekday
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [rtce_pkg::EPOCH_W-1:0]      in_t,
    input  rtce_pkg::rtce_meta_t              in_meta,
    output logic                              out_valid,
    output logic [rtce_pkg::EPOCH_W-1:0]      out_t,
    output rtce_pkg::rtce_meta_t              out_meta,
    output logic [2:0]                        out_weekday
);

    // (v) mod 7: octal digits summed (8 == 1 mod 7), folded, one subtract
    function automatic logic [2:0] mod7(input logic [18:0] v);
        logic [20:0] w;
        logic [5:0]  s;
        logic [3:0]  f;
        w = {2'b0, v};
        s = '0;
        for (int i = 0; i < 7; i++)
        begin
            s = s + {3'b0, w[3*i +: 3]};
        end
        f = {1'b0, s[5:3]} + {1'b0, s[2:0]};
        if (f >= 4'd7)
        begin
            f = f - 4'd7;
        end
        return f[2:0];
    endfunction

    logic                          w1_valid_reg, w2_valid_reg, w3_valid_reg;
    logic [rtce_pkg::EPOCH_W-1:0]  w1_t_reg, w2_t_reg, w3_t_reg;
    rtce_pkg::rtce_meta_t          w1_meta_reg, w2_meta_reg, w3_meta_reg;
    logic [26:0]                   w1_x_reg;
    logic [17:0]                   w1_q_est_reg, w1_q_est_next;
    logic [17:0]                   w2_q_reg, w2_q_next;
    logic [2:0]                    w3_weekday_reg, w3_weekday_next;

    logic [54:0] recip_prod;
    logic [26:0] back_prod;
    logic [26:0] rem;

    // W1: estimate (t >> 7) / 675, low by at most one
    always_comb
    begin
        recip_prod    = {28'b0, in_t[rtce_pkg::EPOCH_W-1:7]} * {27'b0, rtce_pkg::DIV675_RECIP};
        w1_q_est_next = recip_prod[54:37];
    end

    // W2: remainder check fixes the estimate
    always_comb
    begin
        back_prod = {9'b0, w1_q_est_reg} * rtce_pkg::DIV675_DIVISOR;
        rem       = w1_x_reg - back_prod;
        w2_q_next = (rem >= rtce_pkg::DIV675_DIVISOR) ? w1_q_est_reg + 18'd1 : w1_q_est_reg;
    end

    // W3: day 0 of the epoch was a Thursday
    always_comb
    begin
        w3_weekday_next = mod7({1'b0, w2_q_reg} + 19'd4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w1_valid_reg <= 1'b0;
            w2_valid_reg <= 1'b0;
            w3_valid_reg <= 1'b0;
        end
        else
        begin
            w1_valid_reg <= in_valid;
            w2_valid_reg <= w1_valid_reg;
            w3_valid_reg <= w2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        w1_t_reg       <= in_t;
        w1_meta_reg    <= in_meta;
        w1_x_reg       <= in_t[rtce_pkg::EPOCH_W-1:7];
        w1_q_est_reg   <= w1_q_est_next;
        w2_t_reg       <= w1_t_reg;
        w2_meta_reg    <= w1_meta_reg;
        w2_q_reg       <= w2_q_next;
        w3_t_reg       <= w2_t_reg;
        w3_meta_reg    <= w2_meta_reg;
        w3_weekday_reg <= w3_weekday_next;
    end

    assign out_valid   = w3_valid_reg;
    assign out_t       = w3_t_reg;
    assign out_meta    = w3_meta_reg;
    assign out_weekday = w3_weekday_reg;

endmodule

// ===== hdl/rtc_calendar_to_epoch_unit.sv =====
// Top level: RTC calendar fields to Gregorian year, epoch seconds and weekday.
// Throughput: one transfer per cycle, busy stays low; the receiver cannot stall, so
// the 9-stage pipeline (year split, year products, day count, day-to-second multiply,
// time add, 3-stage divide by 86400 with weekday, output register) never waits.
// Reset: rst_n async, clears all stage valid bits; year_offset=68, min_year=70.
module rtc_calendar_to_epoch_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // command channel
    input  logic                                 start,
    output logic                                 busy,
    input  logic [5:0]                           raw_second,
    input  logic [5:0]                           raw_minute,
    input  logic [4:0]                           raw_hour,
    input  logic [4:0]                           raw_day,
    input  logic [3:0]                           raw_month,
    input  logic [6:0]                           raw_year,
    // result channel
    output logic                                 done,
    output logic [1:0]                           status,
    output logic [rtce_pkg::EPOCH_W-1:0]         epoch_seconds,
    output logic [2:0]                           weekday,
    output logic [11:0]                          full_year,
    output logic [3:0]                           month_number,
    // configuration write port
    input  logic                                 cfg_write,
    input  logic [rtce_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rtce_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] year_offset_reg;
    logic [8:0] min_year_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_offset_reg <= rtce_pkg::YEAR_OFFSET_RESET;
            min_year_reg    <= rtce_pkg::MIN_YEAR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rtce_pkg::REG_YEAR_OFFSET: year_offset_reg <= cfg_data[7:0];
                rtce_pkg::REG_MIN_YEAR:    min_year_reg    <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // The pipeline advances every cycle, so a transfer is always taken.
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Stage 1: year, March-based renumbering, time of day, range checks
    // ------------------------------------------------------------------
    logic        s1_valid_reg;
    logic [11:0] s1_y_reg, s1_y_next;
    logic [11:0] s1_full_reg, s1_full_next;
    logic [8:0]  s1_term_reg, s1_term_next;
    logic [4:0]  s1_day_reg;
    logic [16:0] s1_tod_reg, s1_tod_next;
    logic [3:0]  s1_month_reg;
    logic        s1_pre_bad_reg, s1_pre_bad_next;
    logic [4:0]  s1_len_reg, s1_len_next;
    logic        s1_feb_reg, s1_feb_next;

    logic [8:0]  yrs;
    logic        early_month;
    logic [3:0]  march_month;
    logic        mon_bad;
    logic        hms_bad;

    always_comb
    begin
        yrs          = {2'b0, raw_year} + {1'b0, year_offset_reg};
        s1_full_next = rtce_pkg::CAL_YEAR_ORIGIN + {3'b0, yrs};
        // Jan and Feb (and month 0) count as the tail of the previous year
        early_month  = (raw_month <= rtce_pkg::MONTH_FEB);
        s1_y_next    = early_month ? s1_full_next - 12'd1 : s1_full_next;
        march_month  = early_month ? raw_month + 4'd10 : raw_month - 4'd2;
        s1_term_next = rtce_pkg::month_term(march_month);
        s1_tod_next  = ({12'b0, raw_hour} * rtce_pkg::SECS_PER_HOUR)
                     + ({11'b0, raw_minute} * rtce_pkg::SECS_PER_MIN)
                     + {11'b0, raw_second};
        mon_bad      = (raw_month == 4'd0) || (raw_month > rtce_pkg::MONTH_DEC);
        hms_bad      = (raw_hour >= 5'd24) || (raw_minute >= 6'd60) || (raw_second >= 6'd60);
        s1_pre_bad_next = (yrs < min_year_reg) || mon_bad || hms_bad;
        s1_len_next  = rtce_pkg::month_length(raw_month);
        s1_feb_next  = (raw_month == rtce_pkg::MONTH_FEB);
    end

    // ------------------------------------------------------------------
    // Stage 2: century quotients and 365 * y
    // ------------------------------------------------------------------
    logic        s2_valid_reg;
    logic [9:0]  s2_yq_reg;
    logic [5:0]  s2_q100y_reg, s2_q100y_next;
    logic [2:0]  s2_q400y_reg, s2_q400y_next;
    logic [19:0] s2_y365_reg, s2_y365_next;
    logic [4:0]  s2_q100f_reg, s2_q100f_next;
    logic [2:0]  s2_q400f_reg, s2_q400f_next;
    logic [11:0] s2_full_reg;
    logic [8:0]  s2_term_reg;
    logic [4:0]  s2_day_reg;
    logic [16:0] s2_tod_reg;
    logic [3:0]  s2_month_reg;
    logic        s2_pre_bad_reg;
    logic [4:0]  s2_len_reg;
    logic        s2_feb_reg;

    logic [5:0]  q400y_wide;
    logic [5:0]  q100f_wide;
    logic [5:0]  q400f_wide;
    logic [20:0] y365_wide;

    always_comb
    begin
        s2_q100y_next = rtce_pkg::div100(s1_y_reg);
        q400y_wide    = rtce_pkg::div100({2'b0, s1_y_reg[11:2]});
        s2_q400y_next = q400y_wide[2:0];
        q100f_wide    = rtce_pkg::div100(s1_full_reg);
        s2_q100f_next = q100f_wide[4:0];
        q400f_wide    = rtce_pkg::div100({2'b0, s1_full_reg[11:2]});
        s2_q400f_next = q400f_wide[2:0];
        y365_wide     = {9'b0, s1_y_reg} * 21'd365;
        s2_y365_next  = y365_wide[19:0];
    end

    // ------------------------------------------------------------------
    // Stage 3: signed day count, leap rule, day-of-month check
    // ------------------------------------------------------------------
    logic               s3_valid_reg;
    logic signed [18:0] s3_days_reg, s3_days_next;
    logic [16:0]        s3_tod_reg;
    logic               s3_bad_reg, s3_bad_next;
    logic [11:0]        s3_full_reg;
    logic [3:0]         s3_month_reg;

    logic [20:0] day_sum;
    logic [20:0] day_diff;
    logic [11:0] cent_back;
    logic [11:0] quad_back;
    logic        leap;
    logic [5:0]  day_limit;
    logic        day_bad;

    always_comb
    begin
        day_sum   = {1'b0, s2_y365_reg} + {11'b0, s2_yq_reg} + {18'b0, s2_q400y_reg}
                  + {12'b0, s2_term_reg} + {16'b0, s2_day_reg};
        day_diff  = day_sum - {15'b0, s2_q100y_reg} - rtce_pkg::DAY_BIAS;
        s3_days_next = signed'(day_diff[18:0]);

        cent_back = {7'b0, s2_q100f_reg} * 12'd100;
        quad_back = {9'b0, s2_q400f_reg} * 12'd400;
        leap      = ((s2_full_reg[1:0] == 2'b00) && (cent_back != s2_full_reg))
                  || (quad_back == s2_full_reg);
        day_limit = {1'b0, s2_len_reg} + {5'b0, (s2_feb_reg && leap)};
        day_bad   = (s2_day_reg == 5'd0) || ({1'b0, s2_day_reg} > day_limit);
        s3_bad_next = s2_pre_bad_reg || day_bad;
    end

    // ------------------------------------------------------------------
    // Stage 4: days * 86400, kept modulo 2^34
    // ------------------------------------------------------------------
    logic                          s4_valid_reg;
    logic [rtce_pkg::EPOCH_W-1:0]  s4_prod_reg, s4_prod_next;
    logic [16:0]                   s4_tod_reg;
    logic                          s4_bad_reg;
    logic [11:0]                   s4_full_reg;
    logic [3:0]                    s4_month_reg;

    logic signed [36:0] day_secs;

    always_comb
    begin
        day_secs     = s3_days_reg * $signed({1'b0, rtce_pkg::DAY_SECONDS});
        s4_prod_next = day_secs[rtce_pkg::EPOCH_W-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 5: add time of day -> epoch seconds
    // ------------------------------------------------------------------
    logic                          s5_valid_reg;
    logic [rtce_pkg::EPOCH_W-1:0]  s5_t_reg, s5_t_next;
    rtce_pkg::rtce_meta_t          s5_meta_reg, s5_meta_next;

    always_comb
    begin
        s5_t_next              = s4_prod_reg + {17'b0, s4_tod_reg};
        s5_meta_next.bad       = s4_bad_reg;
        s5_meta_next.full_year = s4_full_reg;
        s5_meta_next.month     = s4_month_reg;
    end

    // Stage control: valid bits only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        s1_y_reg       <= s1_y_next;
        s1_full_reg    <= s1_full_next;
        s1_term_reg    <= s1_term_next;
        s1_day_reg     <= raw_day;
        s1_tod_reg     <= s1_tod_next;
        s1_month_reg   <= raw_month;
        s1_pre_bad_reg <= s1_pre_bad_next;
        s1_len_reg     <= s1_len_next;
        s1_feb_reg     <= s1_feb_next;

        s2_yq_reg      <= s1_y_reg[11:2];
        s2_q100y_reg   <= s2_q100y_next;
        s2_q400y_reg   <= s2_q400y_next;
        s2_y365_reg    <= s2_y365_next;
        s2_q100f_reg   <= s2_q100f_next;
        s2_q400f_reg   <= s2_q400f_next;
        s2_full_reg    <= s1_full_reg;
        s2_term_reg    <= s1_term_reg;
        s2_day_reg     <= s1_day_reg;
        s2_tod_reg     <= s1_tod_reg;
        s2_month_reg   <= s1_month_reg;
        s2_pre_bad_reg <= s1_pre_bad_reg;
        s2_len_reg     <= s1_len_reg;
        s2_feb_reg     <= s1_feb_reg;

        s3_days_reg    <= s3_days_next;
        s3_tod_reg     <= s2_tod_reg;
        s3_bad_reg     <= s3_bad_next;
        s3_full_reg    <= s2_full_reg;
        s3_month_reg   <= s2_month_reg;

        s4_prod_reg    <= s4_prod_next;
        s4_tod_reg     <= s3_tod_reg;
        s4_bad_reg     <= s3_bad_reg;
        s4_full_reg    <= s3_full_reg;
        s4_month_reg   <= s3_month_reg;

        s5_t_reg       <= s5_t_next;
        s5_meta_reg    <= s5_meta_next;
    end

    // ------------------------------------------------------------------
    // Stages 6..8: divide by 86400 and weekday
    // ------------------------------------------------------------------
    logic                          wd_valid;
    logic [rtce_pkg::EPOCH_W-1:0]  wd_t;
    rtce_pkg::rtce_meta_t          wd_meta;
    logic [2:0]                    wd_weekday;

    rtce_weekday u_weekday
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s5_valid_reg),
        .in_t        (s5_t_reg),
        .in_meta     (s5_meta_reg),
        .out_valid   (wd_valid),
        .out_t       (wd_t),
        .out_meta    (wd_meta),
        .out_weekday (wd_weekday)
    );

    // ------------------------------------------------------------------
    // Stage 9: output register; a zero timestamp blanks the other fields
    // ------------------------------------------------------------------
    logic                          done_reg;
    rtce_pkg::status_t             status_reg, status_next;
    logic [rtce_pkg::EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic [2:0]                    weekday_reg, weekday_next;
    logic [11:0]                   full_year_reg, full_year_next;
    logic [3:0]                    month_reg, month_next;

    always_comb
    begin
        if (wd_t == '0)
        begin
            status_next    = rtce_pkg::STATUS_ZERO;
            epoch_next     = '0;
            weekday_next   = '0;
            full_year_next = '0;
            month_next     = '0;
        end
        else
        begin
            status_next    = wd_meta.bad ? rtce_pkg::STATUS_INVALID : rtce_pkg::STATUS_OK;
            epoch_next     = wd_t;
            weekday_next   = wd_weekday;
            full_year_next = wd_meta.full_year;
            month_next     = wd_meta.month;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= wd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        epoch_reg     <= epoch_next;
        weekday_reg   <= weekday_next;
        full_year_reg <= full_year_next;
        month_reg     <= month_next;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign epoch_seconds = epoch_reg;
    assign weekday       = weekday_reg;
    assign full_year     = full_year_reg;
    assign month_number  = month_reg;

endmodule

// ===== hdl/rtce_checker.sv =====
// Port-level checker for the calendar-to-epoch unit, bound to the top level.
module rtce_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic [3:0]                       raw_month,
    input logic                             done,
    input logic [1:0]                       status,
    input logic [rtce_pkg::EPOCH_W-1:0]     epoch_seconds,
    input logic [2:0]                       weekday,
    input logic [11:0]                      full_year,
    input logic [3:0]                       month_number
);

    // Every transfer yields one strobe after the fixed latency
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(rtce_pkg::LATENCY) done)
        else $error("transfer without result strobe");

    // No strobe without a transfer at the matching edge
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, rtce_pkg::LATENCY))
        else $error("result strobe without transfer");

    // Zero timestamp blanks every other field
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == rtce_pkg::STATUS_ZERO) |->
            (epoch_seconds == '0 && weekday == 3'd0 && full_year == 12'd0
             && month_number == 4'd0))
        else $error("zero status with non-zero fields");

    // Other statuses carry a non-zero timestamp and a real weekday
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != rtce_pkg::STATUS_ZERO) |->
            ((status == rtce_pkg::STATUS_OK || status == rtce_pkg::STATUS_INVALID)
             && epoch_seconds != '0 && weekday <= 3'd6))
        else $error("bad status, timestamp or weekday");

    // Month travels with its own item through the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != rtce_pkg::STATUS_ZERO) |->
            (month_number == $past(raw_month, rtce_pkg::LATENCY)))
        else $error("month out of step with its transfer");

endmodule

bind rtc_calendar_to_epoch_unit rtce_checker u_rtce_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .raw_month     (raw_month),
    .done          (done),
    .status        (status),
    .epoch_seconds (epoch_seconds),
    .weekday       (weekday),
    .full_year     (full_year),
    .month_number  (month_number)
);

// ===== tb/rtc_calendar_to_epoch_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the RTC calendar-to-epoch conversion unit.
module rtc_calendar_to_epoch_unit_tb;

    // One RTC snapshot as presented on the command channel
    typedef struct {
        logic [5:0] sec;
        logic [5:0] mins;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] mon;
        logic [6:0] ryear;
    } snapshot_t;

    // One converted result as it should appear on the result channel
    typedef struct {
        rtce_pkg::status_t            status;
        logic [rtce_pkg::EPOCH_W-1:0] epoch;
        logic [2:0]                   wday;
        logic [11:0]                  year;
        logic [3:0]                   month;
    } calendar_result_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             busy;
    logic [5:0]                       raw_second = '0;
    logic [5:0]                       raw_minute = '0;
    logic [4:0]                       raw_hour = '0;
    logic [4:0]                       raw_day = '0;
    logic [3:0]                       raw_month = '0;
    logic [6:0]                       raw_year = '0;
    logic                             done;
    logic [1:0]                       status;
    logic [rtce_pkg::EPOCH_W-1:0]     epoch_seconds;
    logic [2:0]                       weekday;
    logic [11:0]                      full_year;
    logic [3:0]                       month_number;
    logic                             cfg_write = 1'b0;
    logic [rtce_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [rtce_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // Local copy of the block's registers, kept in step with every write
    logic [7:0] year_offset_cfg = rtce_pkg::YEAR_OFFSET_RESET;
    logic [8:0] min_year_cfg    = rtce_pkg::MIN_YEAR_RESET;

    int month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    snapshot_t        snapshot_q[$];     // snapshots waiting for the driver
    calendar_result_t epoch_expect_q[$]; // predicted results, oldest first

    int items_queued = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int idle_left    = 0;

    rtc_calendar_to_epoch_unit dut (.*);

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit: far beyond the slowest legal run (~600 transfers, longest idle gaps)
    initial
    begin
        #1_000_000;
        $display("rtc_calendar_to_epoch_unit: mismatch");
        $finish;
    end

    // Days in month mon (1..12) of Gregorian year full
    function automatic int days_in_month(input longint full, input logic [3:0] mon);
        int len;
        len = month_days[mon - 4'd1];
        if (mon == rtce_pkg::MONTH_FEB
            && (((full % 4) == 0 && (full % 100) != 0) || (full % 400) == 0))
            len++;
        return len;
    endfunction

    // Expected conversion of one snapshot under the current register settings
    function automatic calendar_result_t convert_calendar(input snapshot_t s);
        calendar_result_t r;
        longint years, full, y, m, d, hr, mi, se, days, secs, tl;
        logic [rtce_pkg::EPOCH_W-1:0] t;
        logic bad;
        years = s.ryear;
        years = years + year_offset_cfg;
        full  = years + 1900;
        d  = s.day;
        hr = s.hour;
        mi = s.mins;
        se = s.sec;
        // March-based month numbering: Jan and Feb count as months 11..12 and month 0
        // as month 10 of the previous year, everything else shifts down by two
        m = s.mon;
        m = m - 2;
        y = full;
        if (m <= 0)
        begin
            m = m + 12;
            y = y - 1;
        end
        days = y / 4 - y / 100 + y / 400 + (367 * m) / 12 + d + y * 365 - 719499;
        secs = ((days * 24 + hr) * 60 + mi) * 60 + se;
        t    = secs[rtce_pkg::EPOCH_W-1:0];   // pre-1970 dates wrap
        tl   = t;
        if (t == '0)
        begin
            // Zero timestamp: error code and every other field cleared
            r.status = rtce_pkg::STATUS_ZERO;
            r.epoch  = '0;
            r.wday   = '0;
            r.year   = '0;
            r.month  = '0;
        end
        else
        begin
            bad = (years < min_year_cfg) || s.mon < 4'd1 || s.mon > rtce_pkg::MONTH_DEC;
            if (!bad && (s.day < 1 || s.day > days_in_month(full, s.mon)))
                bad = 1'b1;
            if (s.hour >= 24 || s.mins >= 60 || s.sec >= 60)
                bad = 1'b1;
            r.status = bad ? rtce_pkg::STATUS_INVALID : rtce_pkg::STATUS_OK;
            r.epoch  = t;
            r.wday   = 3'((tl / 86400 + 4) % 7);
            r.year   = full[11:0];
            r.month  = s.mon;
        end
        return r;
    endfunction

    // Idle cycles after a transfer: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Driver: presents queued snapshots, holds start until the transfer is taken
    always @(posedge clk or negedge rst_n)
    begin
        snapshot_t snap;
        if (!rst_n)
        begin
            start      <= 1'b0;
            raw_second <= '0;
            raw_minute <= '0;
            raw_hour   <= '0;
            raw_day    <= '0;
            raw_month  <= '0;
            raw_year   <= '0;
            idle_left  <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                snap.sec   = raw_second;
                snap.mins  = raw_minute;
                snap.hour  = raw_hour;
                snap.day   = raw_day;
                snap.mon   = raw_month;
                snap.ryear = raw_year;
                epoch_expect_q.push_back(convert_calendar(snap));
            end
            if (!start || !busy)
            begin
                if (idle_left > 0)
                begin
                    start     <= 1'b0;
                    idle_left <= idle_left - 1;
                end
                else if (snapshot_q.size() != 0)
                begin
                    snap = snapshot_q.pop_front();
                    start      <= 1'b1;
                    raw_second <= snap.sec;
                    raw_minute <= snap.mins;
                    raw_hour   <= snap.hour;
                    raw_day    <= snap.day;
                    raw_month  <= snap.mon;
                    raw_year   <= snap.ryear;
                    idle_left  <= pick_gap();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed result must match the oldest prediction
    always @(posedge clk)
    begin
        calendar_result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (epoch_expect_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: st %0d ep %0d wd %0d yr %0d mo %0d",
                             status, epoch_seconds, weekday, full_year, month_number);
                mismatches++;
            end
            else
            begin
                want = epoch_expect_q.pop_front();
                if (status !== want.status || epoch_seconds !== want.epoch ||
                    weekday !== want.wday || full_year !== want.year ||
                    month_number !== want.month)
                begin
                    if (mismatches < 10)
                        $display("result differs: exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                                 want.status, want.epoch, want.wday, want.year, want.month,
                                 status, epoch_seconds, weekday, full_year, month_number);
                    mismatches++;
                end
            end
        end
    end

    // Register writes, only with the pipeline empty; bit 8 of the offset
    // write is random noise the block must drop
    task automatic load_calendar_config(input logic [7:0] offset, input logic [8:0] min_yr);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= rtce_pkg::REG_YEAR_OFFSET;
        cfg_data  <= {1'($urandom), offset};
        @(posedge clk);
        cfg_index <= rtce_pkg::REG_MIN_YEAR;
        cfg_data  <= min_yr;
        year_offset_cfg = offset;
        @(posedge clk);
        cfg_write <= 1'b0;
        min_year_cfg = min_yr;
    endtask

    task automatic queue_snapshot(input logic [5:0] sec, input logic [5:0] mins,
                                  input logic [4:0] hour, input logic [4:0] day,
                                  input logic [3:0] mon, input logic [6:0] ryear);
        snapshot_t s;
        s.sec   = sec;
        s.mins  = mins;
        s.hour  = hour;
        s.day   = day;
        s.mon   = mon;
        s.ryear = ryear;
        snapshot_q.push_back(s);
        items_queued++;
    endtask

    // Mostly valid dates, in the accepted year range where one exists, some with
    // one field pushed out of range, the rest raw noise
    task automatic queue_random_snapshots(input int count);
        snapshot_t s;
        int kind, lo, full, len;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 15)
            begin
                s.sec   = 6'($urandom);
                s.mins  = 6'($urandom);
                s.hour  = 5'($urandom);
                s.day   = 5'($urandom);
                s.mon   = 4'($urandom);
                s.ryear = 7'($urandom);
            end
            else
            begin
                lo = int'(min_year_cfg) - int'(year_offset_cfg);
                if (lo < 0 || lo > 127)
                    lo = 0;
                s.ryear = 7'($urandom_range(lo, 127));
                full    = 1900 + year_offset_cfg + s.ryear;
                s.mon   = 4'($urandom_range(1, 12));
                len     = days_in_month(full, s.mon);
                s.day   = 5'($urandom_range(1, len));
                s.hour  = 5'($urandom_range(0, 23));
                s.mins  = 6'($urandom_range(0, 59));
                s.sec   = 6'($urandom_range(0, 59));
                if (kind < 40)
                begin
                    case ($urandom_range(0, 4))
                        0: s.day  = (len == 31) ? 5'd0 : 5'($urandom_range(len + 1, 31));
                        1: s.hour = 5'($urandom_range(24, 31));
                        2: s.mins = 6'($urandom_range(60, 63));
                        3: s.sec  = 6'($urandom_range(60, 63));
                        default: s.mon = ($urandom_range(0, 3) == 0) ? 4'd0
                                                                      : 4'($urandom_range(13, 15));
                    endcase
                end
            end
            snapshot_q.push_back(s);
            items_queued++;
        end
    endtask

    task automatic wait_for_drain();
        while (results_seen < items_queued)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: offset 68, minimum year 1970
        queue_snapshot(0, 0, 0, 1, 1, 2);       // epoch origin: zero timestamp
        queue_snapshot(0, 0, 24, 31, 12, 1);    // 1969-12-31 24:00 also lands on zero
        queue_snapshot(1, 0, 0, 1, 1, 2);       // first second after the origin
        queue_snapshot(63, 63, 31, 31, 15, 127);// every field at its top
        queue_snapshot(0, 0, 0, 0, 0, 0);       // every field zero, wraps below 1970
        queue_snapshot(0, 0, 12, 29, 2, 32);    // 2000 is a leap year
        queue_snapshot(0, 0, 12, 29, 2, 33);    // 2001 is not
        queue_snapshot(0, 0, 0, 31, 4, 31);     // 31 April
        queue_snapshot(0, 0, 0, 0, 5, 31);      // day zero
        queue_snapshot(0, 0, 0, 10, 13, 31);    // month 13, still renumbered
        queue_snapshot(59, 59, 23, 15, 6, 31);
        queue_snapshot(59, 59, 24, 15, 6, 31);  // hour out of range
        queue_snapshot(59, 60, 23, 15, 6, 31);  // minute out of range
        queue_snapshot(60, 59, 23, 15, 6, 31);  // second out of range
        queue_snapshot(0, 0, 0, 15, 6, 1);      // 1969: below the minimum year
        queue_snapshot(59, 59, 23, 31, 12, 127);// latest date at this offset
        queue_random_snapshots(58);
        wait_for_drain();

        // Lowest settings: years 1900..2027, nothing below the minimum
        load_calendar_config(8'd0, 9'd0);
        queue_snapshot(0, 0, 0, 1, 1, 0);       // 1900-01-01, wrapped but valid
        queue_snapshot(0, 0, 0, 29, 2, 0);      // 1900 is not a leap year
        queue_snapshot(0, 0, 0, 29, 2, 4);
        queue_random_snapshots(58);
        wait_for_drain();

        // Highest settings: every date below the minimum year
        load_calendar_config(8'd255, 9'd511);
        queue_snapshot(59, 59, 23, 31, 12, 127);// 2282-12-31, largest year
        queue_random_snapshots(58);
        wait_for_drain();

        // Offset 70: the zero timestamp at raw year zero
        load_calendar_config(8'd70, 9'd0);
        queue_snapshot(0, 0, 0, 1, 1, 0);
        queue_random_snapshots(58);
        wait_for_drain();

        // Century rule around 2100, though 2100 lies below the minimum year 2200 here
        load_calendar_config(8'd200, 9'd300);
        queue_snapshot(0, 0, 0, 29, 2, 0);
        queue_snapshot(0, 0, 0, 28, 2, 0);
        queue_random_snapshots(58);
        wait_for_drain();

        load_calendar_config(8'd255, 9'd0);
        queue_random_snapshots(58);
        wait_for_drain();

        load_calendar_config(8'd0, 9'd511);
        queue_random_snapshots(58);
        wait_for_drain();

        for (int p = 0; p < 3; p++)
        begin
            load_calendar_config(8'($urandom), 9'($urandom_range(0, 300)));
            queue_random_snapshots(58);
            wait_for_drain();
        end

        // Let any stray strobe show up before the verdict
        repeat (rtce_pkg::LATENCY + 4) @(posedge clk);
        if (mismatches == 0 && epoch_expect_q.size() == 0)
            $display("rtc_calendar_to_epoch_unit: match");
        else
            $display("rtc_calendar_to_epoch_unit: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/rtce_pkg.sv
hdl/rtce_weekday.sv
hdl/rtc_calendar_to_epoch_unit.sv
hdl/rtce_checker.sv
tb/rtc_calendar_to_epoch_unit_tb.sv
